// ----- rtl/sfa_pkg.sv -----
package sfa_pkg;

  localparam logic [3:0] OP_ADD16   = 4'd0;
  localparam logic [3:0] OP_ADD32   = 4'd1;
  localparam logic [3:0] OP_SUB16   = 4'd2;
  localparam logic [3:0] OP_SUB32   = 4'd3;
  localparam logic [3:0] OP_MULLO16 = 4'd4;
  localparam logic [3:0] OP_MULHI16 = 4'd5;
  localparam logic [3:0] OP_MULLO32 = 4'd6;
  localparam logic [3:0] OP_MULHI32 = 4'd7;
  localparam logic [3:0] OP_DIV16   = 4'd8;
  localparam logic [3:0] OP_DIV32   = 4'd9;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ALU  = 2'd1;
  localparam logic [1:0] KIND_MUL  = 2'd2;
  localparam logic [1:0] KIND_DIV  = 2'd3;

  localparam logic [31:0] SIGN16 = 32'h0000_8000;
  localparam logic [31:0] SIGN32 = 32'h8000_0000;

  localparam int DIV_STAGES = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic        wide;
    logic        high;
    logic        neg;
    logic        special;
    logic [31:0] result;
    logic        carry;
    logic        overflow;
    logic        dz;
  } side_t;

endpackage

// ----- rtl/sfa_prep.sv -----
module sfa_prep import sfa_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [3:0]  op,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output side_t       side_r,
  output logic [31:0] ma_r,
  output logic [31:0] mb_r
);

  logic [15:0] a16, b16, ra16, rb16, s16r, d16r;
  logic [31:0] ra32, rb32, s32r, d32r;
  logic [16:0] s16;
  logic [32:0] s32;
  logic        wide;
  logic [31:0] am, bm;
  side_t       side_nxt;
  logic [31:0] ma_nxt, mb_nxt;

  assign a16  = operand_a[15:0];
  assign b16  = operand_b[15:0];
  assign ra16 = a16[15] ? (16'd0 - a16) : a16;
  assign rb16 = b16[15] ? (16'd0 - b16) : b16;
  assign ra32 = operand_a[31] ? (32'd0 - operand_a) : operand_a;
  assign rb32 = operand_b[31] ? (32'd0 - operand_b) : operand_b;
  assign s16  = {1'b0, a16} + {1'b0, b16};
  assign s32  = {1'b0, operand_a} + {1'b0, operand_b};
  assign s16r = s16[15:0];
  assign s32r = s32[31:0];
  assign d16r = a16 - b16;
  assign d32r = operand_a - operand_b;
  assign wide = (op == OP_ADD32 || op == OP_SUB32 || op == OP_MULLO32 ||
                 op == OP_MULHI32 || op == OP_DIV32);
  assign am   = wide ? operand_a : {16'd0, a16};
  assign bm   = wide ? operand_b : {16'd0, b16};

  always_comb begin
    side_nxt = '0;
    ma_nxt   = wide ? ra32 : {16'd0, ra16};
    mb_nxt   = wide ? rb32 : {16'd0, rb16};
    side_nxt.wide = wide;
    side_nxt.high = (op == OP_MULHI16 || op == OP_MULHI32);
    side_nxt.neg  = wide ? (operand_a[31] ^ operand_b[31]) : (a16[15] ^ b16[15]);
    side_nxt.special = wide ? (am == SIGN32 || bm == SIGN32) : (am == SIGN16 || bm == SIGN16);
    side_nxt.dz   = (bm == 32'd0);
    unique case (op)
      OP_ADD16: begin
        side_nxt.kind     = KIND_ALU;
        side_nxt.result   = {16'd0, s16r};
        side_nxt.carry    = s16[16];
        side_nxt.overflow = ~(a16[15] ^ b16[15]) & (a16[15] ^ s16r[15]);
      end
      OP_ADD32: begin
        side_nxt.kind     = KIND_ALU;
        side_nxt.result   = s32r;
        side_nxt.carry    = s32[32];
        side_nxt.overflow = ~(operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ s32r[31]);
      end
      OP_SUB16: begin
        side_nxt.kind     = KIND_ALU;
        side_nxt.result   = {16'd0, d16r};
        side_nxt.carry    = a16 < b16;
        side_nxt.overflow = (a16[15] ^ b16[15]) & (a16[15] ^ d16r[15]);
      end
      OP_SUB32: begin
        side_nxt.kind     = KIND_ALU;
        side_nxt.result   = d32r;
        side_nxt.carry    = operand_a < operand_b;
        side_nxt.overflow = (operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ d32r[31]);
      end
      OP_MULLO16, OP_MULHI16, OP_MULLO32, OP_MULHI32: side_nxt.kind = KIND_MUL;
      OP_DIV16, OP_DIV32: begin
        side_nxt.kind = KIND_DIV;
        side_nxt.wide = (op == OP_DIV32);
      end
      default: side_nxt.kind = KIND_NONE;
    endcase
    if (op == OP_DIV16 || op == OP_DIV32) begin
      ma_nxt = (op == OP_DIV32) ? ra32 : {16'd0, ra16};
      mb_nxt = (op == OP_DIV32) ? rb32 : {16'd0, rb16};
      side_nxt.neg = (op == OP_DIV32) ? (operand_a[31] ^ operand_b[31]) : (a16[15] ^ b16[15]);
      side_nxt.dz  = (op == OP_DIV32) ? (operand_b == 32'd0) : (b16 == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
    end
  end

endmodule

// ----- rtl/sfa_mul.sv -----
module sfa_mul import sfa_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  side_t       side_in,
  input  logic [31:0] ma,
  input  logic [31:0] mb,
  output side_t       side_r
);

  logic [63:0] p_r, pn;
  side_t       s1_r, side_nxt;

  assign pn = s1_r.neg ? (64'd0 - p_r) : p_r;

  always_comb begin
    side_nxt = s1_r;
    if (s1_r.kind == KIND_MUL) begin
      side_nxt.carry = 1'b0;
      if (s1_r.special) begin
        side_nxt.result   = s1_r.wide ? SIGN32 : SIGN16;
        side_nxt.overflow = 1'b1;
      end else if (s1_r.high) begin
        side_nxt.result   = s1_r.wide ? pn[63:32] : {16'd0, pn[31:16]};
        side_nxt.overflow = 1'b0;
      end else begin
        side_nxt.result   = s1_r.wide ? pn[31:0] : {16'd0, pn[15:0]};
        side_nxt.overflow = s1_r.wide ? (p_r[63:32] != 32'd0) : (p_r[31:16] != 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= {32'd0, ma} * {32'd0, mb};
      s1_r   <= side_in;
      side_r <= side_nxt;
    end
  end

endmodule

// ----- rtl/sfa_div.sv -----
module sfa_div import sfa_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);

  logic [31:0] rem_r [DIV_STAGES];
  logic [31:0] num_r [DIV_STAGES];
  logic [31:0] quo_r [DIV_STAGES];
  logic [31:0] den_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_st
    logic [31:0] rp, np, qp, dp;
    logic [32:0] shifted, trial;
    if (i == 0) begin : g_first
      assign rp = 32'd0;
      assign np = dividend;
      assign qp = 32'd0;
      assign dp = divisor;
    end else begin : g_next
      assign rp = rem_r[i-1];
      assign np = num_r[i-1];
      assign qp = quo_r[i-1];
      assign dp = den_r[i-1];
    end
    assign shifted = {rp, np[31]};
    assign trial   = shifted - {1'b0, dp};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= trial[32] ? shifted[31:0] : trial[31:0];
        num_r[i] <= {np[30:0], 1'b0};
        quo_r[i] <= {qp[30:0], ~trial[32]};
        den_r[i] <= dp;
      end
    end
  end

  assign quotient = quo_r[DIV_STAGES-1];

endmodule

// ----- rtl/signed_fixed_point_alu.sv -----
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_op, in_operand_a, in_operand_b
// out     | out_valid | out_stall | out_result, out_carry, out_overflow, out_divide_by_zero
//
// one beat per cycle unless out_stall freezes the pipeline; the path runs through the operand stage,
// the 32-stage restoring divider and the output register, all ops take the same path length
// rst_n clears only the valid bits
// out_stall with a pending result freezes the whole pipeline and raises in_stall
module signed_fixed_point_alu import sfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic        out_carry,
  output logic        out_overflow,
  output logic        out_divide_by_zero
);

  localparam int DLY = DIV_STAGES - 2;

  logic        en;
  logic [DIV_STAGES:0] vld_r;
  logic        out_valid_r;
  side_t       prep_side, mul_side, fin;
  side_t       dly_r [DLY];
  logic [31:0] ma, mb, quo, qn;
  logic [31:0] result_r;
  logic        carry_r, overflow_r, dz_r;
  logic [31:0] res_nxt;
  logic        carry_nxt, ovf_nxt, dz_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  sfa_prep u_prep (
    .clk(clk), .en(en), .op(in_op), .operand_a(in_operand_a), .operand_b(in_operand_b),
    .side_r(prep_side), .ma_r(ma), .mb_r(mb)
  );

  sfa_mul u_mul (
    .clk(clk), .en(en), .side_in(prep_side), .ma(ma), .mb(mb), .side_r(mul_side)
  );

  sfa_div u_div (
    .clk(clk), .en(en), .dividend(ma), .divisor(mb), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= mul_side;
      for (int i = 1; i < DLY; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  assign fin = dly_r[DLY-1];
  assign qn  = fin.neg ? (32'd0 - quo) : quo;

  always_comb begin
    res_nxt   = fin.result;
    carry_nxt = fin.carry;
    ovf_nxt   = fin.overflow;
    dz_nxt    = 1'b0;
    unique case (fin.kind)
      KIND_DIV: begin
        carry_nxt = 1'b0;
        ovf_nxt   = 1'b0;
        dz_nxt    = fin.dz;
        res_nxt   = fin.dz ? 32'd0 : (fin.wide ? qn : {16'd0, qn[15:0]});
      end
      KIND_NONE: begin
        res_nxt   = 32'd0;
        carry_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DIV_STAGES-1:0], in_valid};
      out_valid_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r   <= res_nxt;
      carry_r    <= carry_nxt;
      overflow_r <= ovf_nxt;
      dz_r       <= dz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = result_r;
  assign out_carry          = carry_r;
  assign out_overflow       = overflow_r;
  assign out_divide_by_zero = dz_r;

`ifndef NO_ASSERTIONS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result == 32'd0)
    else $error("divide by zero with nonzero result");
  a_dz_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_carry && !out_overflow)
    else $error("divide by zero with add or multiply flags");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");
`endif

endmodule
